// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file ipatp_checker
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ipatp_pkg.sv -----
// types and constants of the ip address text parser
// used by ipatp_step, ip_address_text_parser and ipatp_checker
package ipatp_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int OUT_DATA_W  = 136;
    localparam int OUT_USER_W  = 2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};

    typedef enum logic [7:0] {
        PH_START     = 8'b0000_0001,
        PH_LEAD      = 8'b0000_0010,
        PH_AFTER_SEP = 8'b0000_0100,
        PH_AFTER_GAP = 8'b0000_1000,
        PH_TOKEN     = 8'b0001_0000,
        PH_DOT_FIRST = 8'b0010_0000,
        PH_DOT_DIGITS= 8'b0100_0000,
        PH_DONE      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [15:0][7:0]       store;
        logic [4:0]             filled;
        logic [4:0]             gap_pos;
        logic                   gap_seen;
        logic [16:0]            hex;
        logic [8:0]             dec;
        logic [3:0][7:0]        dotted;
        phase_t                 phase;
        logic [COUNT_WIDTH-1:0] count;
        logic                   count_over;
        logic                   tok_dec;
        logic [1:0]             oct_idx;
        logic [COUNT_WIDTH-1:0] tok_end;
        logic [COUNT_WIDTH:0]   used_end;
        logic                   mapped;
    } parse_state_t;

    function automatic parse_state_t clear_state();
        parse_state_t s;
        s = '0;
        s.phase = PH_START;
        return s;
    endfunction

endpackage

// ----- hw/rtl/ipatp_step.sv -----
// one character step of the address parser: next parse state from state and char
// depends on ipatp_pkg
module ipatp_step import ipatp_pkg::*;
(
    input  parse_state_t           state_in,
    input  logic [7:0]             char_code,
    input  logic [COUNT_WIDTH-1:0] pos,
    output parse_state_t           state_out
);

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b0, 4'(c - 8'h37)};
        return r;
    endfunction

    // decimal accumulate, saturating at 256
    function automatic logic [8:0] add_decimal(logic [8:0] dec, logic [3:0] d);
        logic [11:0] prod;
        logic [8:0]  r;
        r = dec;
        prod = (12'(dec) << 3) + (12'(dec) << 1) + 12'(d);
        if (dec < 9'd256)
            r = (prod > 12'd255) ? 9'd256 : prod[8:0];
        return r;
    endfunction

    function automatic parse_state_t take_group(parse_state_t st, logic [COUNT_WIDTH:0] endpos,
                                                logic more);
        parse_state_t r;
        logic [4:0]   nf;
        logic [3:0]   idx1;
        r = st;
        nf = st.filled + 5'd2;
        idx1 = st.filled[3:0] + 4'd1;
        if (st.hex <= 17'h0ffff)
        begin
            r.store[st.filled[3:0]] = st.hex[15:8];
            r.store[idx1] = st.hex[7:0];
            r.filled = nf;
            r.used_end = endpos;
            r.phase = (more && nf < 5'd16) ? PH_AFTER_SEP : PH_DONE;
        end
        else
        begin
            r.phase = PH_DONE;
        end
        return r;
    endfunction

    logic [4:0]             hd;
    logic                   is_hex;
    logic                   dig;
    logic [COUNT_WIDTH:0]   pos_next;
    logic [COUNT_WIDTH:0]   tok_end_x;
    logic [19:0]            acc;
    logic [3:0]             sidx;
    parse_state_t           n;

    assign hd        = hex_digit(char_code);
    assign is_hex    = !hd[4];
    assign dig       = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign pos_next  = (COUNT_WIDTH+1)'(pos) + (COUNT_WIDTH+1)'(1);
    assign tok_end_x = (COUNT_WIDTH+1)'(state_in.tok_end);
    assign acc       = {state_in.hex[15:0], hd[3:0]};

    always_comb
    begin
        n = state_in;
        sidx = '0;
        case (state_in.phase)
            PH_START:
            begin
                if (char_code == CH_COLON)
                    n.phase = PH_LEAD;
                else if (is_hex)
                begin
                    n.hex = {13'b0, hd[3:0]};
                    n.dec = dig ? {5'b0, hd[3:0]} : 9'd0;
                    n.tok_dec = dig;
                    n.phase = PH_TOKEN;
                end
                else
                    n.phase = PH_DONE;
            end
            PH_LEAD:
            begin
                if (char_code == CH_COLON)
                begin
                    n.gap_seen = 1'b1;
                    n.gap_pos = 5'd0;
                    n.used_end = pos_next;
                    n.phase = PH_AFTER_GAP;
                end
                else
                    n.phase = PH_DONE;
            end
            PH_AFTER_SEP:
            begin
                if (char_code == CH_COLON)
                begin
                    // a second gap ends the address
                    if (state_in.gap_seen)
                        n.phase = PH_DONE;
                    else
                    begin
                        n.gap_seen = 1'b1;
                        n.gap_pos = state_in.filled;
                        n.used_end = pos_next;
                        n.phase = PH_AFTER_GAP;
                    end
                end
                else if (is_hex)
                begin
                    n.hex = {13'b0, hd[3:0]};
                    n.dec = dig ? {5'b0, hd[3:0]} : 9'd0;
                    n.tok_dec = dig;
                    n.phase = PH_TOKEN;
                end
                else
                    n.phase = PH_DONE;
            end
            PH_AFTER_GAP:
            begin
                if (is_hex)
                begin
                    n.hex = {13'b0, hd[3:0]};
                    n.dec = dig ? {5'b0, hd[3:0]} : 9'd0;
                    n.tok_dec = dig;
                    n.phase = PH_TOKEN;
                end
                else
                    n.phase = PH_DONE;
            end
            PH_TOKEN:
            begin
                if (is_hex)
                begin
                    if (state_in.hex < 17'h10000)
                        n.hex = (acc[19:16] != 4'd0) ? 17'h10000 : {1'b0, acc[15:0]};
                    if (dig)
                        n.dec = add_decimal(state_in.dec, hd[3:0]);
                    else
                        n.tok_dec = 1'b0;
                end
                else if (char_code == CH_DOT && state_in.tok_dec && state_in.filled <= 5'd12
                         && state_in.dec <= 9'd255)
                begin
                    n.dotted[0] = state_in.dec[7:0];
                    n.oct_idx = 2'd1;
                    n.tok_end = pos;
                    n.phase = PH_DOT_FIRST;
                end
                else
                    n = take_group(state_in, (COUNT_WIDTH+1)'(pos), char_code == CH_COLON);
            end
            PH_DOT_FIRST:
            begin
                if (dig)
                begin
                    n.dec = {5'b0, hd[3:0]};
                    n.phase = PH_DOT_DIGITS;
                end
                else
                    n = take_group(state_in, tok_end_x, 1'b0);
            end
            PH_DOT_DIGITS:
            begin
                if (dig)
                    n.dec = add_decimal(state_in.dec, hd[3:0]);
                else if (state_in.dec > 9'd255)
                    n = take_group(state_in, tok_end_x, 1'b0);
                else
                begin
                    n.dotted[state_in.oct_idx] = state_in.dec[7:0];
                    if (state_in.oct_idx < 2'd3)
                    begin
                        if (char_code == CH_DOT)
                        begin
                            n.oct_idx = state_in.oct_idx + 2'd1;
                            n.phase = PH_DOT_FIRST;
                        end
                        else
                            n = take_group(state_in, tok_end_x, 1'b0);
                    end
                    else
                    begin
                        // plain dotted text maps to ::ffff form
                        if (state_in.filled == 5'd0 && !state_in.gap_seen)
                            n.mapped = 1'b1;
                        else
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                sidx = state_in.filled[3:0] + 4'(k);
                                n.store[sidx] = n.dotted[k];
                            end
                            n.filled = state_in.filled + 5'd4;
                        end
                        n.used_end = (COUNT_WIDTH+1)'(pos);
                        n.phase = PH_DONE;
                    end
                end
            end
            default:
            begin
                n.phase = PH_DONE;
            end
        endcase
    end

    assign state_out = n;

endmodule

// ----- hw/rtl/ip_address_text_parser.sv -----
// top level of the ip address text parser
// depends on ipatp_pkg and ipatp_step
//
// input stream: one text character per transfer in s_axis_tdata, s_axis_tlast on
// the final character of the text. output stream: one result transfer per text,
// sent after its last character. the result holds the 128-bit address in network
// order, the character count used, a valid flag and a flag for plain dotted ipv4
// text mapped to ::ffff form; an invalid result carries all zeros.
// an input register feeds combinational parse logic, which also runs the
// end-of-text step and the gap expansion, into a result register.
// throughput: one character per cycle while s_axis_tready is high. the result of a
// text is loaded into the result register once its last character leaves the input register.
// reset clears the parse state and drops any pending character and result.
// when the receiver stalls, the result register holds; characters keep flowing
// until a second last character reaches the input register, which then waits
// and s_axis_tready drops until the pending result is taken.
module ip_address_text_parser import ipatp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] char_code
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] addr_high, [127:64] addr_low,
                                                  // [135:128] chars_used
    output logic [OUT_USER_W-1:0] m_axis_tuser    // [0] valid_res, [1] from_dotted_v4
);

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_last_reg;
    logic                  advance;

    parse_state_t          state_reg;
    parse_state_t          state_cnt;
    parse_state_t          state_mid;
    parse_state_t          state_fin;
    parse_state_t          state_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic [OUT_USER_W-1:0] out_user_next;

    // a non-last character never needs the result register
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // character count moves before the step sees the character
    always_comb
    begin
        state_cnt = state_reg;
        if (state_reg.count < COUNT_LIMIT)
            state_cnt.count = state_reg.count + COUNT_WIDTH'(1);
        else
            state_cnt.count_over = 1'b1;
    end

    ipatp_step u_step_char
    (
        .state_in  (state_cnt),
        .char_code (in_char_reg),
        .pos       (state_reg.count),
        .state_out (state_mid)
    );

    // end-of-text step, fed a nul character
    ipatp_step u_step_end
    (
        .state_in  (state_mid),
        .char_code (8'h00),
        .pos       (state_cnt.count),
        .state_out (state_fin)
    );

    assign state_next = in_last_reg ? clear_state() : state_mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= clear_state();
        else if (advance)
            state_reg <= state_next;
    end

    // result assembly: bytes before the gap stay, bytes after it go to the end; mapped text gives ::ffff form
    always_comb
    begin
        logic [15:0][7:0] addr;
        logic [4:0]       g;
        logic [4:0]       tail_start;
        logic [3:0]       ridx;
        logic             res_valid;
        logic [63:0]      addr_high;
        logic [63:0]      addr_low;

        addr = '0;
        ridx = '0;
        g = state_fin.gap_seen ? state_fin.gap_pos : 5'd16;
        if (g > state_fin.filled)
            g = state_fin.filled;
        tail_start = 5'd16 - (state_fin.filled - g);

        if (state_fin.mapped)
        begin
            res_valid = 1'b1;
            addr[10] = 8'hff;
            addr[11] = 8'hff;
            for (int k = 0; k < 4; k++)
                addr[12 + k] = state_fin.dotted[k];
        end
        else
        begin
            res_valid = state_fin.gap_seen ? (state_fin.filled < 5'd16)
                                           : (state_fin.filled == 5'd16);
            for (int k = 0; k < 16; k++)
            begin
                ridx = 4'(k) + state_fin.filled[3:0];
                if (5'(k) < g)
                    addr[k] = state_fin.store[k];
                else if (5'(k) >= tail_start)
                    addr[k] = state_fin.store[ridx];
            end
        end
        if (state_fin.count_over)
            res_valid = 1'b0;

        for (int k = 0; k < 8; k++)
        begin
            addr_high[63 - 8*k -: 8] = addr[k];
            addr_low[63 - 8*k -: 8]  = addr[8 + k];
        end

        if (res_valid)
            out_data_next = {8'(state_fin.used_end), addr_low, addr_high};
        else
            out_data_next = '0;
        out_user_next = {res_valid && state_fin.mapped, res_valid};
    end

    always_comb
    begin
        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- hw/rtl/ipatp_checker.sv -----
// port-level checks of the ip address text parser, bound to the top level
// depends on ipatp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ipatp_checker import ipatp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [7:0]            s_axis_tdata,   // [7:0] char_code
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] addr_high, [127:64] addr_low,
                                                 // [135:128] chars_used
    input logic [OUT_USER_W-1:0] m_axis_tuser    // [0] valid_res, [1] from_dotted_v4
);

    logic in_xfer_last;
    logic in_char_seen;

    assign in_xfer_last = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign in_char_seen = (s_axis_tdata == s_axis_tdata);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed in stall")

    // an invalid result carries zeros only
    `ASSERT_IMPLY(a_invalid_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata == '0 && m_axis_tuser == '0, "invalid result not zero")

    // mapped dotted text gives a valid result with the ::ffff prefix
    `ASSERT_IMPLY(a_mapped_form, clk, rst_n, m_axis_tvalid && m_axis_tuser[1],
        m_axis_tuser[0] && m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[127:96] == 32'h0000ffff,
        "mapped result malformed")

    // a fresh result follows the transfer of a last character
    `ASSERT_IMPLY(a_result_source, clk, rst_n, $rose(m_axis_tvalid),
        $past(in_xfer_last, 2) && in_char_seen, "result without last character")

endmodule

bind ip_address_text_parser ipatp_checker u_ipatp_checker (.*);
